@@ sv/wsc_iap_pkg.sv @@
package wsc_iap_pkg;

	localparam int RESULT_DEPTH = 4;
	localparam int KNOWN_TYPES = 20;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_OUI = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_LEN = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;

	localparam logic [1:0] DEC_U16 = 2'd0;
	localparam logic [1:0] DEC_U8 = 2'd1;
	localparam logic [1:0] DEC_FLAG = 2'd2;
	localparam logic [1:0] DEC_NONE = 2'd3;

	localparam logic KIND_ATTR = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_COMPLETE = 2'd0;
	localparam logic [1:0] ST_NO_OUI = 2'd1;
	localparam logic [1:0] ST_OVERRUN = 2'd2;

	localparam logic [7:0] WSC_OUI [4] = '{8'h00, 8'h50, 8'hF2, 8'h04};

	localparam logic [15:0] KNOWN_TYPE [KNOWN_TYPES] = '{
		16'h1002, 16'h1008, 16'h1009, 16'h1011, 16'h1012, 16'h1021, 16'h1023,
		16'h1024, 16'h103A, 16'h103B, 16'h103C, 16'h1041, 16'h1042, 16'h1044,
		16'h1047, 16'h1048, 16'h104A, 16'h1053, 16'h1054, 16'h1057
	};

	localparam logic [1:0] TYPE_DECODE [KNOWN_TYPES] = '{
		DEC_U16, DEC_U16, DEC_U16, DEC_NONE, DEC_U16, DEC_NONE, DEC_NONE,
		DEC_NONE, DEC_U8, DEC_U8, DEC_U8, DEC_FLAG, DEC_NONE, DEC_U8,
		DEC_NONE, DEC_NONE, DEC_U8, DEC_U16, DEC_NONE, DEC_FLAG
	};

	typedef struct packed {
		logic hit;
		logic [4:0] code;
		logic [1:0] dec;
	} lookup_t;

	typedef struct packed {
		logic kind;
		logic [4:0] code;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] value;
		logic [1:0] status;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic lookup_t type_lookup(input logic [15:0] t);
		lookup_t l;
		l = '{hit: 1'b0, code: 5'd0, dec: DEC_NONE};
		for (int i = 0; i < KNOWN_TYPES; i++) begin
			if (t == KNOWN_TYPE[i]) begin
				l.hit = 1'b1;
				l.code = 5'(i);
				l.dec = TYPE_DECODE[i];
			end
		end
		return l;
	endfunction

endpackage

@@ sv/wsc_iap_core.sv @@
module wsc_iap_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic room,
	output wsc_iap_pkg::push_t push
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic adv;

	logic [15:0] pos_q, n_pos;
	logic [2:0] phase_q, n_phase;
	logic oui_q, n_oui;
	logic [15:0] type_q, n_type;
	logic [15:0] len_q, n_len;
	logic [15:0] left_q, n_left;
	logic [15:0] vc_q, n_vc;
	logic [15:0] rs_q, n_rs;

	logic fin;
	logic [1:0] oui_idx;
	logic [15:0] len_full;
	logic [15:0] done_cnt;
	logic [1:0] status;
	logic [15:0] value;
	wsc_iap_pkg::lookup_t lk;
	wsc_iap_pkg::result_t attr_r;
	wsc_iap_pkg::result_t stat_r;

	assign adv = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign oui_idx = pos_q[1:0] - 2'd2;
	assign len_full = {len_q[15:8], byte_s1};
	assign done_cnt = len_q - left_q;

	always_comb begin
		n_pos = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
		n_phase = phase_q;
		n_oui = oui_q;
		n_type = type_q;
		n_len = len_q;
		n_left = left_q;
		n_vc = vc_q;
		n_rs = rs_q;
		fin = 1'b0;
		unique case (phase_q)
			wsc_iap_pkg::PH_HEADER: begin
				if (pos_q != 16'd0) begin
					n_phase = wsc_iap_pkg::PH_OUI;
				end
			end
			wsc_iap_pkg::PH_OUI: begin
				if (byte_s1 != wsc_iap_pkg::WSC_OUI[oui_idx]) begin
					n_oui = 1'b0;
				end
				if (pos_q >= 16'd5) begin
					n_phase = n_oui ? wsc_iap_pkg::PH_TYPE : wsc_iap_pkg::PH_SKIP;
				end
			end
			wsc_iap_pkg::PH_TYPE: begin
				if (left_q == 16'd0) begin
					n_rs = pos_q;
					n_type = {byte_s1, 8'h00};
					n_left = 16'd1;
				end else begin
					n_type = {type_q[15:8], byte_s1};
					n_left = 16'd0;
					n_phase = wsc_iap_pkg::PH_LEN;
				end
			end
			wsc_iap_pkg::PH_LEN: begin
				if (left_q == 16'd0) begin
					n_len = {byte_s1, 8'h00};
					n_left = 16'd1;
				end else begin
					n_len = len_full;
					n_vc = 16'd0;
					if (len_full == 16'd0) begin
						n_left = 16'd0;
						n_phase = wsc_iap_pkg::PH_TYPE;
						fin = 1'b1;
					end else begin
						n_left = len_full;
						n_phase = wsc_iap_pkg::PH_DATA;
					end
				end
			end
			wsc_iap_pkg::PH_DATA: begin
				if (done_cnt == 16'd0) begin
					n_vc = {byte_s1, 8'h00};
				end else if (done_cnt == 16'd1) begin
					n_vc = {vc_q[15:8], byte_s1};
				end
				n_left = left_q - 16'd1;
				if (left_q == 16'd1) begin
					n_phase = wsc_iap_pkg::PH_TYPE;
					fin = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign lk = wsc_iap_pkg::type_lookup(type_q);

	always_comb begin
		unique case (lk.dec)
			wsc_iap_pkg::DEC_U16: value = n_vc;
			wsc_iap_pkg::DEC_U8: value = {8'h00, n_vc[15:8]};
			wsc_iap_pkg::DEC_FLAG: value = {15'd0, |n_vc[15:8]};
			default: value = 16'd0;
		endcase
	end

	always_comb begin
		priority if (!n_oui || n_phase == wsc_iap_pkg::PH_HEADER
			|| n_phase == wsc_iap_pkg::PH_OUI || n_phase == wsc_iap_pkg::PH_SKIP) begin
			status = wsc_iap_pkg::ST_NO_OUI;
		end else if (n_phase == wsc_iap_pkg::PH_TYPE && n_left == 16'd0) begin
			status = wsc_iap_pkg::ST_COMPLETE;
		end else begin
			status = wsc_iap_pkg::ST_OVERRUN;
		end
	end

	always_comb begin
		attr_r = '0;
		attr_r.kind = wsc_iap_pkg::KIND_ATTR;
		attr_r.code = lk.code;
		attr_r.offset = rs_q + 16'd4;
		attr_r.length = n_len;
		attr_r.value = value;
		attr_r.status = wsc_iap_pkg::ST_COMPLETE;
		attr_r.last = !last_s1;
		stat_r = '0;
		stat_r.kind = wsc_iap_pkg::KIND_STATUS;
		stat_r.status = status;
		stat_r.last = 1'b1;
		push.r0 = stat_r;
		push.r1 = stat_r;
		push.cnt = 2'd0;
		if (adv) begin
			if (fin && lk.hit) begin
				push.r0 = attr_r;
				push.cnt = last_s1 ? 2'd2 : 2'd1;
			end else begin
				push.cnt = last_s1 ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 16'd0;
			phase_q <= wsc_iap_pkg::PH_HEADER;
			oui_q <= 1'b1;
			type_q <= 16'd0;
			len_q <= 16'd0;
			left_q <= 16'd0;
			vc_q <= 16'd0;
			rs_q <= 16'd0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q <= 16'd0;
				phase_q <= wsc_iap_pkg::PH_HEADER;
				oui_q <= 1'b1;
				type_q <= 16'd0;
				len_q <= 16'd0;
				left_q <= 16'd0;
				vc_q <= 16'd0;
				rs_q <= 16'd0;
			end else begin
				pos_q <= n_pos;
				phase_q <= n_phase;
				oui_q <= n_oui;
				type_q <= n_type;
				len_q <= n_len;
				left_q <= n_left;
				vc_q <= n_vc;
				rs_q <= n_rs;
			end
		end
	end

`ifndef SYNTHESIS
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == wsc_iap_pkg::PH_HEADER && pos_q == 16'd0)
		else $error("parser state not cleared after final byte");
	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> last_s1 && push.r1.kind == wsc_iap_pkg::KIND_STATUS)
		else $error("two results without an end-of-element status");
	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsc_iap_pkg::PH_DATA |-> left_q != 16'd0)
		else $error("data phase with no bytes left");
`endif

endmodule

@@ sv/wsc_iap_fifo.sv @@
module wsc_iap_fifo #(
	parameter int DEPTH = wsc_iap_pkg::RESULT_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input wsc_iap_pkg::push_t push,
	output logic room,
	output logic out_valid,
	input logic out_ready,
	output wsc_iap_pkg::result_t out_data
);

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wsc_iap_pkg::result_t mem [DEPTH];
	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_q;
	logic [PW-1:0] wr1;
	logic [CW-1:0] count_q;
	logic pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr1 = ptr_inc(wr_q);
	assign pop = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_data = mem[rd_q];
	assign room = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (push.cnt == 2'd1) begin
				wr_q <= wr1;
			end else if (push.cnt == 2'd2) begin
				wr_q <= ptr_inc(wr1);
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd0 && pop |=> count_q == $past(count_q) - 1'b1)
		else $error("result count wrong after a pop");
`endif

endmodule

@@ sv/wsc_iap_attribute_parser_top_unused_placeholder.sv @@
module wsc_iap_check (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic m_tuser
);

	logic open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			open_q <= !m_tlast;
		end
	end

`ifndef SYNTHESIS
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("status transaction without last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction withdrawn");
	a_last_attr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && open_q |-> m_tuser)
		else $error("status transaction missing after a final attribute");
`endif

endmodule

@@ sv/wsc_ie_attribute_parser.sv @@
// Parses one WSC vendor information element streamed one byte per transaction on s_*, with
// tlast on the final byte. Every known attribute record yields one transaction on m_* when its
// last data byte (or, for a zero-length record, its second length byte) arrives, and the final
// byte adds a status transaction with tuser high; tlast marks the last transaction of a byte.
// One byte is accepted per cycle while the result queue has room. Each accepted byte first waits
// in the input register while the parser works on it, and its results are then written into a
// small queue that drives m_* directly. Input stalls only when that queue holds more than
// FIFO_DEPTH - 2 results, so at the default FIFO_DEPTH only a stalled master side slows the
// input.
module wsc_ie_attribute_parser #(
	parameter int FIFO_DEPTH = wsc_iap_pkg::RESULT_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // ie_byte
	input logic s_tlast, // end_of_element
	output logic m_tvalid,
	input logic m_tready,
	// attribute_code, data_offset, record_length, attribute_value, parse_status, zero pad
	output logic [55:0] m_tdata,
	output logic m_tlast, // last_result
	output logic m_tuser // result_kind
);

	wsc_iap_pkg::push_t push;
	wsc_iap_pkg::result_t res;
	logic room;

	wsc_iap_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.in_last(s_tlast),
		.room(room),
		.push(push)
	);

	wsc_iap_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(res)
	);

	wsc_iap_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	assign m_tdata = {1'b0, res.status, res.value, res.length, res.offset, res.code};
	assign m_tlast = res.last;
	assign m_tuser = res.kind;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] RX_READY = 2'd0;
	localparam logic [1:0] RX_RANDOM = 2'd1;
	localparam logic [1:0] RX_PATTERN = 2'd2;

	localparam int RANDOM_BYTES = 1650;

	typedef struct {
		logic [7:0] data;
		logic last;
	} ie_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	ie_beat_t ie_pending[$];
	ie_beat_t next_beat;
	logic [7:0] element_bytes[$];
	wsc_iap_pkg::result_t awaited_results[$];
	wsc_iap_pkg::result_t got_result;
	wsc_iap_pkg::result_t want_result;

	logic [15:0] pos_q;
	logic [2:0] phase;
	logic oui_ok;
	logic [15:0] rec_type;
	logic [15:0] rec_len;
	logic [15:0] remaining;
	logic [15:0] captured;
	logic [15:0] rec_start;

	int burst_left;
	int gap_left;
	logic [1:0] rx_mode;
	int rx_mode_left;
	logic [15:0] rx_pattern;
	logic [3:0] rx_phase;

	int error_count = 0;
	int bytes_accepted = 0;
	int attr_seen = 0;
	int status_seen[3] = '{0, 0, 0};
	int bytes_built = 0;

	wsc_ie_attribute_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what);
		$display("error at %0t: %s", $time, what);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report($sformatf("field %s got %h, expected %h", name, got, want));
	endtask

	task automatic clear_parser();
		pos_q = 16'd0;
		phase = wsc_iap_pkg::PH_HEADER;
		oui_ok = 1'b1;
		rec_type = 16'd0;
		rec_len = 16'd0;
		remaining = 16'd0;
		captured = 16'd0;
		rec_start = 16'd0;
	endtask

	function automatic logic decode_attribute(output wsc_iap_pkg::result_t r);
		logic hit;
		hit = 1'b0;
		r = '0;
		for (int i = 0; i < wsc_iap_pkg::KNOWN_TYPES; i++) begin
			if (rec_type == wsc_iap_pkg::KNOWN_TYPE[i]) begin
				hit = 1'b1;
				r.kind = wsc_iap_pkg::KIND_ATTR;
				r.code = 5'(i);
				r.offset = rec_start + 16'd4;
				r.length = rec_len;
				r.last = 1'b1;
				unique case (wsc_iap_pkg::TYPE_DECODE[i])
					wsc_iap_pkg::DEC_U16: r.value = captured;
					wsc_iap_pkg::DEC_U8: r.value = {8'h00, captured[15:8]};
					wsc_iap_pkg::DEC_FLAG: r.value = {15'd0, |captured[15:8]};
					default: r.value = 16'd0;
				endcase
			end
		end
		return hit;
	endfunction

	task automatic parse_ie_byte(input logic [7:0] b, input logic eoe);
		wsc_iap_pkg::result_t made[$];
		wsc_iap_pkg::result_t r;
		logic [15:0] done;
		unique case (phase)
			wsc_iap_pkg::PH_HEADER: begin
				if (pos_q >= 16'd1)
					phase = wsc_iap_pkg::PH_OUI;
			end
			wsc_iap_pkg::PH_OUI: begin
				if (b != wsc_iap_pkg::WSC_OUI[2'(pos_q - 16'd2)])
					oui_ok = 1'b0;
				if (pos_q >= 16'd5)
					phase = oui_ok ? wsc_iap_pkg::PH_TYPE : wsc_iap_pkg::PH_SKIP;
			end
			wsc_iap_pkg::PH_TYPE: begin
				if (remaining == 16'd0) begin
					rec_start = pos_q;
					rec_type = {b, 8'h00};
					remaining = 16'd1;
				end else begin
					rec_type[7:0] = b;
					remaining = 16'd0;
					phase = wsc_iap_pkg::PH_LEN;
				end
			end
			wsc_iap_pkg::PH_LEN: begin
				if (remaining == 16'd0) begin
					rec_len = {b, 8'h00};
					remaining = 16'd1;
				end else begin
					rec_len[7:0] = b;
					captured = 16'd0;
					if (rec_len == 16'd0) begin
						remaining = 16'd0;
						phase = wsc_iap_pkg::PH_TYPE;
						if (decode_attribute(r))
							made.push_back(r);
					end else begin
						remaining = rec_len;
						phase = wsc_iap_pkg::PH_DATA;
					end
				end
			end
			wsc_iap_pkg::PH_DATA: begin
				done = rec_len - remaining;
				if (done == 16'd0)
					captured = {b, 8'h00};
				else if (done == 16'd1)
					captured[7:0] = b;
				remaining = remaining - 16'd1;
				if (remaining == 16'd0) begin
					phase = wsc_iap_pkg::PH_TYPE;
					if (decode_attribute(r))
						made.push_back(r);
				end
			end
			default: begin
			end
		endcase
		if (pos_q != 16'hFFFF)
			pos_q = pos_q + 16'd1;
		if (eoe) begin
			if (made.size() != 0) begin
				r = made.pop_back();
				r.last = 1'b0;
				made.push_back(r);
			end
			r = '0;
			r.kind = wsc_iap_pkg::KIND_STATUS;
			r.last = 1'b1;
			if (!oui_ok || phase == wsc_iap_pkg::PH_HEADER || phase == wsc_iap_pkg::PH_OUI
				|| phase == wsc_iap_pkg::PH_SKIP)
				r.status = wsc_iap_pkg::ST_NO_OUI;
			else if (phase == wsc_iap_pkg::PH_TYPE && remaining == 16'd0)
				r.status = wsc_iap_pkg::ST_COMPLETE;
			else
				r.status = wsc_iap_pkg::ST_OVERRUN;
			made.push_back(r);
			clear_parser();
		end
		foreach (made[i])
			awaited_results.push_back(made[i]);
	endtask

	task automatic commit_element();
		ie_beat_t beat;
		while (element_bytes.size() != 0) begin
			beat.data = element_bytes.pop_front();
			beat.last = (element_bytes.size() == 0);
			ie_pending.push_back(beat);
			bytes_built++;
		end
	endtask

	function automatic logic [7:0] data_byte();
		return ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom);
	endfunction

	task automatic push_record(input logic [15:0] t, input logic [15:0] len, input int fill);
		element_bytes.push_back(t[15:8]);
		element_bytes.push_back(t[7:0]);
		element_bytes.push_back(len[15:8]);
		element_bytes.push_back(len[7:0]);
		repeat (fill)
			element_bytes.push_back(data_byte());
	endtask

	function automatic logic [15:0] pick_type();
		if ($urandom_range(0, 4) != 0)
			return wsc_iap_pkg::KNOWN_TYPE[$urandom_range(0, wsc_iap_pkg::KNOWN_TYPES - 1)];
		return 16'($urandom);
	endfunction

	function automatic int pick_length();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return $urandom_range(0, 3);
		if (roll < 19)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	task automatic random_element();
		int mode;
		int len;
		int keep;
		logic [7:0] flip;
		mode = $urandom_range(0, 19);
		element_bytes.push_back(8'($urandom));
		element_bytes.push_back(8'($urandom));
		for (int i = 0; i < 4; i++)
			element_bytes.push_back(wsc_iap_pkg::WSC_OUI[i]);
		if (mode == 0) begin
			keep = $urandom_range(2, 5);
			flip = 8'(1 << $urandom_range(0, 7));
			element_bytes[keep] = element_bytes[keep] ^ flip;
		end
		repeat ($urandom_range(0, 5)) begin
			len = pick_length();
			push_record(pick_type(), 16'(len), len);
		end
		if (mode == 1) begin
			keep = $urandom_range(1, 5);
		end else if (mode == 2 || mode == 3) begin
			keep = (element_bytes.size() > 7) ? $urandom_range(7, element_bytes.size() - 1) : 6;
		end else if (mode == 4) begin
			push_record(pick_type(), 16'($urandom) | 16'h0100, $urandom_range(0, 8));
			keep = element_bytes.size();
		end else begin
			keep = element_bytes.size();
		end
		while (element_bytes.size() > keep)
			void'(element_bytes.pop_back());
		commit_element();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (ie_pending.size() != 0) begin
				next_beat = ie_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_beat.data;
				s_tlast <= next_beat.last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_READY;
			rx_mode_left <= 0;
			rx_pattern <= 16'hFFFF;
			rx_phase <= 4'd0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= 2'($urandom_range(0, 2));
				rx_mode_left <= $urandom_range(16, 200);
				rx_pattern <= 16'($urandom);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			rx_phase <= rx_phase + 4'd1;
			unique case (rx_mode)
				RX_READY: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: m_tready <= rx_pattern[rx_phase];
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_ie_byte(s_tdata, s_tlast);
				bytes_accepted++;
			end
			if (m_tvalid && m_tready) begin
				got_result.kind = m_tuser;
				got_result.code = m_tdata[4:0];
				got_result.offset = m_tdata[20:5];
				got_result.length = m_tdata[36:21];
				got_result.value = m_tdata[52:37];
				got_result.status = m_tdata[54:53];
				got_result.last = m_tlast;
				if (awaited_results.size() == 0) begin
					report($sformatf("unexpected result %h", got_result));
				end else begin
					want_result = awaited_results.pop_front();
					check_field("result_kind", 16'(got_result.kind), 16'(want_result.kind));
					check_field("attribute_code", 16'(got_result.code),
						16'(want_result.code));
					check_field("data_offset", got_result.offset, want_result.offset);
					check_field("record_length", got_result.length, want_result.length);
					check_field("attribute_value", got_result.value, want_result.value);
					check_field("parse_status", 16'(got_result.status),
						16'(want_result.status));
					check_field("last_result", 16'(got_result.last), 16'(want_result.last));
					check_field("tdata padding", 16'(m_tdata[55]), 16'd0);
					if (want_result.kind == wsc_iap_pkg::KIND_STATUS)
						status_seen[want_result.status]++;
					else
						attr_seen++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		clear_parser();
		element_bytes = '{8'hDD};
		commit_element();
		element_bytes = '{8'hDD, 8'h0D, 8'h00, 8'h50, 8'hF2, 8'h04, 8'h10, 8'h12, 8'h00, 8'h01,
			8'hFF, 8'h10, 8'h57, 8'h00, 8'h00};
		commit_element();
		element_bytes = '{8'hDD, 8'h06, 8'h00, 8'h50, 8'hF2, 8'h05, 8'h10, 8'h02};
		commit_element();
		while (bytes_built < RANDOM_BYTES)
			random_element();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (ie_pending.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Parsed %0d bytes in %0d elements under random input gaps and output stalls.",
			bytes_accepted, status_seen[0] + status_seen[1] + status_seen[2]);
		$display("Attributes: %0d; status complete/no OUI/overrun: %0d/%0d/%0d.",
			attr_seen, status_seen[0], status_seen[1], status_seen[2]);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
